### hw/rtl/hpa_pkg.sv
// Shared types, register map and constants for the HSL pixel adjuster.
`timescale 1ns / 1ps
package hpa_pkg;

  localparam int unsigned HUE_W   = 15;
  localparam int unsigned CHAN_W  = 17;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // 1.0 in the lightness, saturation and alpha fixed point
  localparam logic [CHAN_W-1:0] UNIT_ONE = 17'd65536;
  // 360 degrees in 1/64 degree units
  localparam logic [HUE_W:0]    HUE_FULL = 16'd23040;

  localparam logic [CHAN_W-1:0] STEP_RESET  = 17'd6554;
  localparam logic [HUE_W-1:0]  SNAP1_RESET = 15'd704;
  localparam logic [HUE_W-1:0]  SNAP2_RESET = 15'd13824;

  typedef enum logic [2:0] {
    MODE_LIGHTEN    = 3'd0,
    MODE_DARKEN     = 3'd1,
    MODE_SATURATE   = 3'd2,
    MODE_DESATURATE = 3'd3,
    MODE_GRAYSCALE  = 3'd4,
    MODE_ROTATE     = 3'd5,
    MODE_SNAP       = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_STEP   = 3'd1,
    REG_OFFSET = 3'd2,
    REG_SNAP1  = 3'd3,
    REG_SNAP2  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    mode_t             mode;
    logic [CHAN_W-1:0] step;
    logic [HUE_W-1:0]  offset;
    logic [HUE_W-1:0]  snap1;
    logic [HUE_W-1:0]  snap2;
  } cfg_t;

endpackage

### hw/rtl/hpa_if.sv
// Pixel stream interfaces: HSLA input items and adjusted output items.
`timescale 1ns / 1ps
interface hpa_pixel_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] in_hue;
  logic [16:0] in_sat;
  logic [16:0] in_light;
  logic [16:0] in_alpha;

  modport source (output valid, output in_hue, output in_sat, output in_light,
                  output in_alpha, input ready);
  modport sink   (input valid, input in_hue, input in_sat, input in_light,
                  input in_alpha, output ready);
endinterface

interface hpa_pixel_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] out_hue;
  logic [16:0] out_sat;
  logic [16:0] out_light;
  logic [16:0] out_alpha;

  modport source (output valid, output out_hue, output out_sat, output out_light,
                  output out_alpha, input ready);
  modport sink   (input valid, input out_hue, input out_sat, input out_light,
                  input out_alpha, output ready);
endinterface

### hw/rtl/hpa_cfg_regs.sv
// APB register file holding the adjust mode, step, hue offset and snap targets.
`timescale 1ns / 1ps
module hpa_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hpa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output hpa_pkg::cfg_t                  cfg
);
  import hpa_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_LIGHTEN;
      cfg.step   <= STEP_RESET;
      cfg.offset <= '0;
      cfg.snap1  <= SNAP1_RESET;
      cfg.snap2  <= SNAP2_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   cfg.mode   <= mode_t'(pwdata[2:0]);
        REG_STEP:   cfg.step   <= pwdata[CHAN_W-1:0];
        REG_OFFSET: cfg.offset <= pwdata[HUE_W-1:0];
        REG_SNAP1:  cfg.snap1  <= pwdata[HUE_W-1:0];
        REG_SNAP2:  cfg.snap2  <= pwdata[HUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {{(APB_DATA_W-3){1'b0}}, cfg.mode};
      REG_STEP:   prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, cfg.step};
      REG_OFFSET: prdata = {{(APB_DATA_W-HUE_W){1'b0}}, cfg.offset};
      REG_SNAP1:  prdata = {{(APB_DATA_W-HUE_W){1'b0}}, cfg.snap1};
      REG_SNAP2:  prdata = {{(APB_DATA_W-HUE_W){1'b0}}, cfg.snap2};
      default:    prdata = '0;
    endcase
  end

endmodule

### hw/rtl/hpa_pipe.sv
// Three-stage pixel datapath: step add/sub and hue sums, clamp and hue select,
// final hue wrap into the output register.
`timescale 1ns / 1ps
module hpa_pipe (
  input  logic          clk,
  input  logic          rst,
  input  hpa_pkg::cfg_t cfg,
  hpa_pixel_in_if.sink  in_px,
  hpa_pixel_out_if.source out_px
);
  import hpa_pkg::*;

  // stage occupancy and per-stage load enables
  logic s1_valid, s2_valid, s3_valid;
  logic acc1, acc2, acc3;

  // stage 1 registers
  logic [HUE_W-1:0]  s1_hue;
  logic [HUE_W:0]    s1_hue_sum;
  logic [HUE_W-1:0]  s1_dist1, s1_dist2;
  logic [CHAN_W:0]   s1_sat, s1_light;
  logic [CHAN_W-1:0] s1_alpha;

  // stage 2 registers
  logic [HUE_W:0]    s2_hue;
  logic [CHAN_W-1:0] s2_sat, s2_light, s2_alpha;

  // stage 3 (output) registers
  logic [HUE_W-1:0]  s3_hue;
  logic [CHAN_W-1:0] s3_sat, s3_light, s3_alpha;

  // stage 1 logic
  logic [CHAN_W-1:0] tgt_in, tgt_diff;
  logic [CHAN_W:0]   tgt_sum, sat_n, light_n;
  logic              tgt_lt;
  logic [HUE_W:0]    hue_sum_n;
  logic [HUE_W-1:0]  dist1_n, dist2_n;

  // stage 2 and 3 logic
  logic [HUE_W:0]    hue2_n, hue3_wrap;

  assign acc3 = !s3_valid || out_px.ready;
  assign acc2 = !s2_valid || acc3;
  assign acc1 = !s1_valid || acc2;
  assign in_px.ready = acc1;

  always_comb begin
    tgt_in = (cfg.mode inside {MODE_SATURATE, MODE_DESATURATE}) ? in_px.in_sat
                                                                  : in_px.in_light;
    tgt_sum  = {1'b0, tgt_in} + {1'b0, cfg.step};
    tgt_lt   = tgt_in < cfg.step;
    tgt_diff = tgt_in - cfg.step;
    sat_n    = {1'b0, in_px.in_sat};
    light_n  = {1'b0, in_px.in_light};
    case (cfg.mode)
      MODE_LIGHTEN:    light_n = tgt_sum;
      MODE_DARKEN:     light_n = tgt_lt ? '0 : {1'b0, tgt_diff};
      MODE_SATURATE:   sat_n   = tgt_sum;
      MODE_DESATURATE: sat_n   = tgt_lt ? '0 : {1'b0, tgt_diff};
      MODE_GRAYSCALE:  sat_n   = '0;
      default: ;
    endcase
    hue_sum_n = {1'b0, in_px.in_hue} + {1'b0, cfg.offset};
    dist1_n = (in_px.in_hue >= cfg.snap1) ? in_px.in_hue - cfg.snap1
                                          : cfg.snap1 - in_px.in_hue;
    dist2_n = (in_px.in_hue >= cfg.snap2) ? in_px.in_hue - cfg.snap2
                                          : cfg.snap2 - in_px.in_hue;
  end

  always_comb begin
    case (cfg.mode)
      MODE_ROTATE: hue2_n = (s1_hue_sum >= HUE_FULL) ? s1_hue_sum - HUE_FULL
                                                     : s1_hue_sum;
      // ties go to the second target
      MODE_SNAP:   hue2_n = (s1_dist1 >= s1_dist2) ? {1'b0, cfg.snap2}
                                                   : {1'b0, cfg.snap1};
      default:     hue2_n = {1'b0, s1_hue};
    endcase
    // a rotated sum can exceed two full turns' worth minus one, so wrap again
    hue3_wrap = (cfg.mode == MODE_ROTATE && s2_hue >= HUE_FULL) ? s2_hue - HUE_FULL
                                                                : s2_hue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (acc1) s1_valid <= in_px.valid;
      if (acc2) s2_valid <= s1_valid;
      if (acc3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc1 && in_px.valid) begin
      s1_hue     <= in_px.in_hue;
      s1_hue_sum <= hue_sum_n;
      s1_dist1   <= dist1_n;
      s1_dist2   <= dist2_n;
      s1_sat     <= sat_n;
      s1_light   <= light_n;
      s1_alpha   <= in_px.in_alpha;
    end
    if (acc2 && s1_valid) begin
      s2_hue   <= hue2_n;
      s2_sat   <= (s1_sat > {1'b0, UNIT_ONE}) ? UNIT_ONE : s1_sat[CHAN_W-1:0];
      s2_light <= (s1_light > {1'b0, UNIT_ONE}) ? UNIT_ONE : s1_light[CHAN_W-1:0];
      s2_alpha <= s1_alpha;
    end
    if (acc3 && s2_valid) begin
      s3_hue   <= hue3_wrap[HUE_W-1:0];
      s3_sat   <= s2_sat;
      s3_light <= s2_light;
      s3_alpha <= s2_alpha;
    end
  end

  assign out_px.valid     = s3_valid;
  assign out_px.out_hue   = s3_hue;
  assign out_px.out_sat   = s3_sat;
  assign out_px.out_light = s3_light;
  assign out_px.out_alpha = s3_alpha;

  a_out_clamped: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_sat <= UNIT_ONE && s3_light <= UNIT_ONE))
    else $error("output saturation or lightness above 1.0");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !acc1) |=> s1_valid)
    else $error("stage 1 item dropped while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !acc2) |=> s2_valid)
    else $error("stage 2 item dropped while stalled");

  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    (in_px.valid && in_px.ready) |=> s1_valid)
    else $error("accepted item not captured in stage 1");

endmodule

### hw/rtl/hsl_pixel_adjust.sv
// HSL pixel adjuster top level: register file and three-stage pixel pipeline.
//
// Usage: HSLA pixels enter on in_px (valid/ready) and leave adjusted on out_px.
// Hue is in 1/64 degree units; saturation, lightness and alpha use 1.0 = 65536.
// The APB port sets the mode (lighten, darken, saturate, desaturate,
// grayscale, rotate hue, snap hue), the step, the hue offset and two snap
// targets; write it only while no item is in flight. pready is always high.
// Path: an accepted item moves through the three register stages (step add/sub,
// clamp and hue select, hue wrap), and its result is then presented on out_px.
// Throughput: one item per cycle, sustained while out_px.ready stays high.
// Stall: when the receiver drops ready, the result holds in the output
// register and the earlier stages fill up; in_px.ready falls only once all
// three stages hold an item. Nothing is lost or repeated.
// Reset (rst, synchronous): empties the pipeline and loads the register
// defaults: lighten mode, step 0.1, offset 0, snap targets 11 and 216 degrees.
`timescale 1ns / 1ps
module hsl_pixel_adjust (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hpa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  hpa_pixel_in_if.sink                   in_px,
  hpa_pixel_out_if.source                out_px
);
  import hpa_pkg::*;

  cfg_t cfg;

  hpa_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpa_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_px  (in_px),
    .out_px (out_px)
  );

endmodule

### tb/hsl_pixel_adjust_tb.sv
// Self-checking testbench for hsl_pixel_adjust: random HSLA pixels under all modes.
`timescale 1ns / 1ps

typedef struct packed {
  logic [hpa_pkg::HUE_W-1:0]  hue;
  logic [hpa_pkg::CHAN_W-1:0] sat;
  logic [hpa_pkg::CHAN_W-1:0] light;
  logic [hpa_pkg::CHAN_W-1:0] alpha;
} hsla_t;

class pixel_scoreboard;
  logic [2:0]                 mode;
  logic [hpa_pkg::CHAN_W-1:0] step;
  logic [hpa_pkg::HUE_W-1:0]  offset;
  logic [hpa_pkg::HUE_W-1:0]  snap1;
  logic [hpa_pkg::HUE_W-1:0]  snap2;
  hsla_t                      adjusted_q[$];
  int unsigned                checked;
  int unsigned                mismatches;

  function new();
    mode       = hpa_pkg::MODE_LIGHTEN;
    step       = hpa_pkg::STEP_RESET;
    offset     = '0;
    snap1      = hpa_pkg::SNAP1_RESET;
    snap2      = hpa_pkg::SNAP2_RESET;
    checked    = 0;
    mismatches = 0;
  endfunction

  function void set_reg(hpa_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      hpa_pkg::REG_MODE:   mode   = value[2:0];
      hpa_pkg::REG_STEP:   step   = value[hpa_pkg::CHAN_W-1:0];
      hpa_pkg::REG_OFFSET: offset = value[hpa_pkg::HUE_W-1:0];
      hpa_pkg::REG_SNAP1:  snap1  = value[hpa_pkg::HUE_W-1:0];
      hpa_pkg::REG_SNAP2:  snap2  = value[hpa_pkg::HUE_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned add_clip(int unsigned v, int unsigned amt);
    return (v + amt > hpa_pkg::UNIT_ONE) ? hpa_pkg::UNIT_ONE : v + amt;
  endfunction

  function logic [hpa_pkg::CHAN_W-1:0] clip(int unsigned v);
    return (v > hpa_pkg::UNIT_ONE) ? hpa_pkg::UNIT_ONE : v[hpa_pkg::CHAN_W-1:0];
  endfunction

  function int unsigned pending();
    return adjusted_q.size();
  endfunction

  // Work out the adjusted pixel for an accepted input and queue it.
  function void note_pixel(hsla_t px);
    int unsigned hue;
    int unsigned sat;
    int unsigned light;
    int unsigned dist1;
    int unsigned dist2;
    hsla_t       want;
    hue   = px.hue;
    sat   = px.sat;
    light = px.light;
    case (mode)
      hpa_pkg::MODE_LIGHTEN:    light = add_clip(light, step);
      hpa_pkg::MODE_DARKEN:     light = (light < step) ? 0 : light - step;
      hpa_pkg::MODE_SATURATE:   sat = add_clip(sat, step);
      hpa_pkg::MODE_DESATURATE: sat = (sat < step) ? 0 : sat - step;
      hpa_pkg::MODE_GRAYSCALE:  sat = 0;
      hpa_pkg::MODE_ROTATE:     hue = (hue + offset) % hpa_pkg::HUE_FULL;
      hpa_pkg::MODE_SNAP: begin
        // plain distance, not around the circle; a tie picks the second target
        dist1 = (hue >= snap1) ? hue - snap1 : snap1 - hue;
        dist2 = (hue >= snap2) ? hue - snap2 : snap2 - hue;
        hue   = (dist1 >= dist2) ? snap2 : snap1;
      end
      default: ;
    endcase
    want.hue   = hue[hpa_pkg::HUE_W-1:0];
    want.sat   = clip(sat);
    want.light = clip(light);
    want.alpha = px.alpha;
    adjusted_q.push_back(want);
  endfunction

  function void check_pixel(hsla_t got);
    hsla_t want;
    if (adjusted_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel: hue=%0d sat=%0d light=%0d alpha=%0d",
                 got.hue, got.sat, got.light, got.alpha);
      return;
    end
    want = adjusted_q.pop_front();
    checked++;
    if (got.hue !== want.hue || got.sat !== want.sat ||
        got.light !== want.light || got.alpha !== want.alpha) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected hue=%0d sat=%0d light=%0d alpha=%0d, %s%0d %s%0d %s%0d %s%0d",
                 want.hue, want.sat, want.light, want.alpha,
                 "got hue=", got.hue, "sat=", got.sat,
                 "light=", got.light, "alpha=", got.alpha);
    end
  endfunction
endclass

module hsl_pixel_adjust_tb;
  import hpa_pkg::*;

  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_LIGHT} rx_pattern_t;

  localparam logic [2:0]  MODE_SPARE    = 3'd7;
  localparam logic [2:0]  MODE_LIST [8] = '{MODE_LIGHTEN, MODE_DARKEN, MODE_SATURATE,
                                            MODE_DESATURATE, MODE_GRAYSCALE, MODE_ROTATE,
                                            MODE_SNAP, MODE_SPARE};
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_PIXELS  = 125;
  localparam int unsigned LONG_HOLD     = 64;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned TAIL_CYCLES   = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  hpa_pixel_in_if  in_px ();
  hpa_pixel_out_if out_px ();

  hsl_pixel_adjust uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_px   (in_px),
    .out_px  (out_px)
  );

  pixel_scoreboard sb = new;

  int unsigned burst_left    = 0;
  bit          no_gaps       = 1'b0;
  bit          hold_toggle   = 1'b0;
  bit          hold_seen;
  int unsigned hold_left;
  int unsigned rx_seg_left;
  rx_pattern_t rx_kind;
  int unsigned quiet_cycles  = 0;
  int unsigned pixels_sent   = 0;
  int unsigned settings_used = 0;

  always #5 clk = ~clk;

  // Output side: segments of steady, choppy or lightly gapped ready, plus a
  // long hold-off whenever the stimulus flips hold_toggle.
  always @(posedge clk) begin
    if (rst) begin
      out_px.ready <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
      rx_seg_left  <= 0;
      rx_kind      <= RX_STEADY;
    end else if (hold_toggle != hold_seen) begin
      hold_seen    <= hold_toggle;
      hold_left    <= LONG_HOLD;
      out_px.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_px.ready <= 1'b0;
    end else if (rx_seg_left == 0) begin
      rx_seg_left  <= $urandom_range(4, 40);
      rx_kind      <= rx_pattern_t'($urandom_range(0, 2));
      out_px.ready <= 1'b1;
    end else begin
      rx_seg_left <= rx_seg_left - 1;
      case (rx_kind)
        RX_STEADY: out_px.ready <= 1'b1;
        RX_CHOPPY: out_px.ready <= 1'($urandom_range(0, 1));
        default:   out_px.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_px.valid && out_px.ready)
      sb.check_pixel({out_px.out_hue, out_px.out_sat, out_px.out_light, out_px.out_alpha});
  end

  always @(posedge clk) begin
    if (rst || psel || (in_px.valid && in_px.ready) || (out_px.valid && out_px.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Call right after a rising edge with the pixel side idle.
  task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic drain_pixels();
    in_px.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_pixel(hsla_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      // some bursts run straight into the next one
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        in_px.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_px.valid    <= 1'b1;
    in_px.in_hue   <= px.hue;
    in_px.in_sat   <= px.sat;
    in_px.in_light <= px.light;
    in_px.in_alpha <= px.alpha;
    do @(posedge clk); while (!in_px.ready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return CHAN_W'($urandom_range(0, 65536));
    if (k < 8) return CHAN_W'($urandom_range(0, 1) ? $urandom_range(0, 24)
                                                    : $urandom_range(65512, 65560));
    return CHAN_W'($urandom_range(0, 131071));
  endfunction

  initial begin
    hsla_t                 px;
    hsla_t                 corner [3];
    logic [APB_DATA_W-1:0] step_val;
    logic [APB_DATA_W-1:0] offset_val;
    int unsigned           k;

    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_px.valid    <= 1'b0;
    in_px.in_hue   <= '0;
    in_px.in_sat   <= '0;
    in_px.in_light <= '0;
    in_px.in_alpha <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corners: all zero, all ones (over-range hue and channels), and a pixel
    // that sits on the midpoint of the default snap targets and underflows darken.
    corner[0] = {15'd0, 17'd0, 17'd0, 17'd0};
    corner[1] = {15'h7FFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF};
    corner[2] = {15'd7264, UNIT_ONE, 17'd1000, UNIT_ONE};
    apb_write(REG_OFFSET, 32'd23039);
    for (int m = 0; m < 8; m++) begin
      apb_write(REG_MODE, 32'(MODE_LIST[m]));
      settings_used++;
      for (int c = 0; c < 3; c++) send_pixel(corner[c]);
      drain_pixels();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ((p + 3) % 5)
        0:       step_val = 0;
        1:       step_val = 32'(UNIT_ONE);
        2:       step_val = 32'h1FFFF;
        3:       step_val = $urandom_range(0, 65536);
        default: step_val = $urandom_range(0, 131071);
      endcase
      case ($urandom_range(0, 3))
        0:       offset_val = 0;
        1:       offset_val = 23039;
        2:       offset_val = 32'h7FFF;
        default: offset_val = $urandom_range(0, 32767);
      endcase
      apb_write(REG_MODE, 32'(MODE_LIST[(p < 8) ? p : p % 4]));
      apb_write(REG_STEP, step_val);
      apb_write(REG_OFFSET, offset_val);
      apb_write(REG_SNAP1, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 23039));
      apb_write(REG_SNAP2, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 23039));
      settings_used++;

      // Back-pressure: hold the output off while items keep coming in.
      if (p == 1) begin
        no_gaps     = 1'b1;
        hold_toggle <= ~hold_toggle;
      end

      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (p == 1 && i == 80) no_gaps = 1'b0;
        if (p == 6 && i == PHASE_PIXELS / 2) drain_pixels();
        k = $urandom_range(0, 9);
        if (k < 7)      px.hue = HUE_W'($urandom_range(0, 23039));
        else if (k < 9) px.hue = HUE_W'($urandom_range(0, 32767));
        else            px.hue = HUE_W'((int'(sb.snap1) + int'(sb.snap2)) / 2);  // tie when sum is even
        px.sat   = rand_chan();
        px.light = rand_chan();
        px.alpha = CHAN_W'($urandom_range(0, 131071));
        send_pixel(px);
      end
      drain_pixels();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d pixels over %0d register settings: all eight mode codes,",
             pixels_sent, settings_used);
    $display("clamped steps, hue wrap, snap ties and a long output hold-off; %0d checked, %0d bad.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/hpa_pkg.sv
hw/rtl/hpa_if.sv
hw/rtl/hpa_cfg_regs.sv
hw/rtl/hpa_pipe.sv
hw/rtl/hsl_pixel_adjust.sv
tb/hsl_pixel_adjust_tb.sv
